// ===== sv/fcdma_pkg.sv =====
// shared types, codes and helper functions of the four-channel dma controller
package fcdma_pkg;

   localparam logic [2:0] OP_SRC  = 3'd0;
   localparam logic [2:0] OP_DST  = 3'd1;
   localparam logic [2:0] OP_CNT  = 3'd2;
   localparam logic [2:0] OP_CTL  = 3'd3;
   localparam logic [2:0] OP_TRIG = 3'd4;
   localparam logic [2:0] OP_IMM  = 3'd5;
   localparam logic [2:0] OP_TICK = 3'd6;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_SRC_STEP = 2'd1;
   localparam logic [1:0] ERR_MODE     = 2'd2;

   localparam logic [1:0] STEP_INC    = 2'd0;
   localparam logic [1:0] STEP_DEC    = 2'd1;
   localparam logic [1:0] STEP_FIXED  = 2'd2;
   localparam logic [1:0] STEP_RELOAD = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  channel;
      logic [31:0] write_data;
      logic [2:0]  trigger_mode;
      logic        fifo_below_half;
   } req_word_type;

   typedef struct packed {
      logic        xfer_valid;
      logic [27:0] src_address;
      logic [27:0] dst_address;
      logic        xfer_wide;
      logic        irq_valid;
      logic [1:0]  irq_channel;
      logic [3:0]  active_mask;
      logic [15:0] control_readback;
      logic [1:0]  error_code;
   } rsp_word_type;

   typedef struct packed {
      logic [27:0] source_reg;
      logic [27:0] dest_reg;
      logic [27:0] cur_source;
      logic [27:0] cur_dest;
      logic [21:0] length;
      logic [21:0] done_count;
      logic [15:0] count_low;
   } chan_rec_type;

   function automatic logic [2:0] chan_mode(input logic [15:0] ctl, input logic arm7);
      return arm7 ? {1'b0, ctl[13:12]} : ctl[13:11];
   endfunction

   function automatic logic [21:0] load_length(input logic [15:0] ctl,
                                               input logic [15:0] cnt,
                                               input logic arm7,
                                               input logic is_ch3);
      logic [21:0] n;
      if (!arm7) begin
         n = {1'b0, ctl[4:0], cnt};
         if (n == '0) n = 22'h200000;
      end else if (is_ch3) begin
         n = {6'd0, cnt};
         if (n == '0) n = 22'h010000;
      end else begin
         n = {8'd0, cnt[13:0]};
         if (n == '0) n = 22'h004000;
      end
      return n;
   endfunction

   function automatic logic [27:0] step_addr(input logic [27:0] a, input logic [1:0] sel,
                                             input logic wide);
      logic [27:0] unit;
      unit = wide ? 28'd4 : 28'd2;
      if (sel == STEP_DEC) return a - unit;
      if (sel == STEP_FIXED) return a;
      return a + unit;
   endfunction

endpackage

// ===== sv/fcdma_pick.sv =====
// lowest-numbered active channel picker
module fcdma_pick #(
   parameter int CHANNELS = 4,
   parameter int IDX_W = 2
) (
   input  logic [CHANNELS-1:0] mask,
   output logic [IDX_W-1:0]    idx,
   output logic                any
);
   always_comb begin
      idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (mask[i]) idx = IDX_W'(i);
      end
      any = |mask;
   end
endmodule

// ===== sv/four_channel_dma_controller.sv =====
// four-channel dma controller top level
// usage: the req channel takes one word per operation: a register write (source,
// destination, count, control) for the addressed channel, a trigger with its start
// mode, an immediate start, or a transfer tick. every req word yields exactly one
// rsp word with the unit moved (addresses and width), the completion interrupt,
// the active set, the addressed control register and an error code.
// the csr port holds the cpu variant bit; write it only while idle (not enforced).
// channel state (addresses, count, progress) sits in one synchronous memory of
// one entry per channel; each word reads its entry, modifies it and writes it back.
// on acceptance the channel entry is read into a register, the execute state
// modifies it and writes it back, then the rsp word is shown; a trigger stays in
// the execute state and visits every channel through the memory port.
// one word is in flight at a time: req_stall is high from acceptance until the
// rsp word is taken, and while rsp_stall is high the rsp word holds.
// reset clears the control registers, the active set and the channel valid bits, so
// the memory reads as zero until written; no clearing pass is needed.
module four_channel_dma_controller #(
   parameter int CHANNELS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fcdma_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fcdma_pkg::rsp_word_type rsp_word,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data
);
   import fcdma_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type           state_ff;
   logic                arm7_ff;
   logic [15:0]         ctl_ff [CHANNELS];
   logic [15:0]         ctl_in [CHANNELS];
   logic [CHANNELS-1:0] rel_ff, rel_in;
   logic [CHANNELS-1:0] act_ff, act_in;
   logic [CHANNELS-1:0] imm_ff, imm_in;
   logic [CHANNELS-1:0] valid_ff;

   chan_rec_type        mem [CHANNELS];
   chan_rec_type        rd_data_ff;
   logic                rd_valid_ff;
   chan_rec_type        rec, rec_in;
   logic [IDX_W-1:0]    rd_addr;

   req_word_type        req_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                ok_ff;
   logic                any_ff;
   logic [IDX_W-1:0]    pick_idx;
   logic                pick_any;

   logic                xv_in, xv_ff, wide_in, wide_ff, iv_in, iv_ff;
   logic [27:0]         sa_in, sa_ff, da_in, da_ff;
   logic [1:0]          ic_in, ic_ff, err_in, err_ff;
   logic                last_step;
   logic                accept;

   fcdma_pick #(.CHANNELS(CHANNELS), .IDX_W(IDX_W)) u_pick (
      .mask(act_ff),
      .idx (pick_idx),
      .any (pick_any)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign last_step = (req_ff.op != OP_TRIG) || (32'(idx_ff) == CHANNELS - 1);
   assign rec       = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      rd_addr = idx_ff + 1'b1;
      if (state_ff == ST_IDLE) begin
         unique case (req_word.op)
            OP_TRIG: rd_addr = '0;
            OP_TICK: rd_addr = pick_idx;
            default: rd_addr = IDX_W'(req_word.channel);
         endcase
      end
   end

   always_comb begin
      logic [15:0] ctl;
      logic [15:0] nctl;
      logic [2:0]  m;
      logic        is3;
      logic [1:0]  ssel;
      ctl    = ctl_ff[idx_ff];
      nctl   = req_ff.write_data[15:0];
      is3    = (32'(idx_ff) == 3);
      m      = chan_mode(nctl, arm7_ff);
      ssel   = ctl[8:7];
      rec_in = rec;
      ctl_in = ctl_ff;
      rel_in = rel_ff;
      act_in = act_ff;
      imm_in = imm_ff;
      xv_in = 1'b0; sa_in = '0; da_in = '0; wide_in = 1'b0;
      iv_in = 1'b0; ic_in = '0; err_in = ERR_NONE;
      unique case (req_ff.op)
         OP_SRC: if (ok_ff) rec_in.source_reg = req_ff.write_data[27:0];
         OP_DST: if (ok_ff) rec_in.dest_reg = req_ff.write_data[27:0];
         OP_CNT: if (ok_ff) rec_in.count_low = req_ff.write_data[15:0];
         OP_CTL: begin
            if (ok_ff) begin
               ctl_in[idx_ff] = nctl;
               if (nctl[8:7] == 2'd3) err_in = ERR_SRC_STEP;
               if (!ctl[15] && nctl[15]) begin
                  rec_in.cur_source = (arm7_ff && idx_ff == '0) ?
                                      {1'b0, rec.source_reg[26:0]} : rec.source_reg;
                  rec_in.cur_dest   = (arm7_ff && !is3) ?
                                      {1'b0, rec.dest_reg[26:0]} : rec.dest_reg;
                  rec_in.length     = load_length(nctl, rec.count_low, arm7_ff, is3);
                  rec_in.done_count = '0;
                  rel_in[idx_ff]    = 1'b0;
                  if (m == 3'd0) begin
                     imm_in[idx_ff] = 1'b1;
                  end else if (!arm7_ff && m == 3'd7) begin
                     if (req_ff.fifo_below_half) act_in[idx_ff] = 1'b1;
                  end else if ((!arm7_ff && (m == 3'd4 || m == 3'd6)) ||
                               (arm7_ff && m == 3'd3)) begin
                     err_in = ERR_MODE;
                  end
               end
            end
         end
         OP_TRIG: begin
            if (ctl[15] && chan_mode(ctl, arm7_ff) == req_ff.trigger_mode) begin
               if (rel_ff[idx_ff]) begin
                  rel_in[idx_ff] = 1'b0;
                  rec_in.length  = load_length(ctl, rec.count_low, arm7_ff, is3);
                  if (ctl[6:5] == STEP_RELOAD)
                     rec_in.cur_dest = (arm7_ff && !is3) ?
                                       {1'b0, rec.dest_reg[26:0]} : rec.dest_reg;
               end
               act_in[idx_ff] = 1'b1;
            end
         end
         OP_IMM: begin
            act_in = act_ff | imm_ff;
            imm_in = '0;
         end
         OP_TICK: begin
            if (any_ff) begin
               if (rec.done_count < rec.length) begin
                  xv_in   = 1'b1;
                  sa_in   = rec.cur_source;
                  da_in   = rec.cur_dest;
                  wide_in = ctl[10];
                  rec_in.done_count = rec.done_count + 1'b1;
                  rec_in.cur_source = step_addr(rec.cur_source,
                                                (ssel == 2'd3) ? STEP_INC : ssel, ctl[10]);
                  rec_in.cur_dest   = step_addr(rec.cur_dest, ctl[6:5], ctl[10]);
               end
               if (rec_in.done_count == rec.length) begin
                  if (ctl[14]) begin
                     iv_in = 1'b1;
                     ic_in = 2'(idx_ff);
                  end
                  if (ctl[9]) rel_in[idx_ff] = 1'b1;
                  else ctl_in[idx_ff] = {1'b0, ctl[14:0]};
                  rec_in.done_count = '0;
                  act_in[idx_ff] = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         arm7_ff     <= 1'b0;
         rel_ff      <= '0;
         act_ff      <= '0;
         imm_ff      <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) ctl_ff[i] <= '0;
      end else begin
         if (csr_write_enable) arm7_ff <= csr_write_data;
         rd_valid_ff <= valid_ff[rd_addr];
         unique case (state_ff)
            ST_IDLE: if (accept) state_ff <= ST_EXEC;
            ST_EXEC: begin
               ctl_ff <= ctl_in;
               rel_ff <= rel_in;
               act_ff <= act_in;
               imm_ff <= imm_in;
               valid_ff[idx_ff] <= 1'b1;
               if (last_step) state_ff <= ST_OUT;
            end
            ST_OUT: if (!rsp_stall) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (state_ff == ST_EXEC) begin
         mem[idx_ff] <= rec_in;
         idx_ff  <= idx_ff + 1'b1;
         xv_ff   <= xv_in;
         sa_ff   <= sa_in;
         da_ff   <= da_in;
         wide_ff <= wide_in;
         iv_ff   <= iv_in;
         ic_ff   <= ic_in;
         err_ff  <= err_in;
      end
      if (accept) begin
         req_ff <= req_word;
         idx_ff <= rd_addr;
         ok_ff  <= (32'(req_word.channel) < CHANNELS);
         any_ff <= pick_any;
      end
   end

   always_comb begin
      rsp_word.xfer_valid       = xv_ff;
      rsp_word.src_address      = sa_ff;
      rsp_word.dst_address      = da_ff;
      rsp_word.xfer_wide        = wide_ff;
      rsp_word.irq_valid        = iv_ff;
      rsp_word.irq_channel      = ic_ff;
      rsp_word.active_mask      = 4'(act_ff);
      rsp_word.control_readback = ok_ff ? ctl_ff[IDX_W'(req_ff.channel)] : 16'd0;
      rsp_word.error_code       = err_ff;
   end

   // no new word while a result is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> req_stall)
      else $error("req taken while rsp pending");

   // a completing channel has left the active set
   a_irq_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.irq_valid) |-> !act_ff[IDX_W'(rsp_word.irq_channel)])
      else $error("interrupting channel still active");

   // units only move on a tick
   a_xfer_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.xfer_valid) |-> (req_ff.op == OP_TICK))
      else $error("transfer without tick");

   // immediate start drains the pending set
   a_imm_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && req_ff.op == OP_IMM) |=> (imm_ff == '0))
      else $error("immediate pending not cleared");
endmodule

// ===== verif/four_channel_dma_controller_tb.sv =====
// self-checking testbench of the four-channel dma controller
`timescale 1ns / 1ps

module four_channel_dma_controller_tb;
   import fcdma_pkg::*;

   localparam logic [2:0] OP_NONE = 3'd7;
   localparam logic [15:0] CTL_ENABLE = 16'h8000;
   localparam logic [15:0] CTL_IRQ = 16'h4000;
   localparam logic [15:0] CTL_REPEAT = 16'h0200;
   localparam logic [15:0] CTL_WIDE = 16'h0400;
   localparam logic [2:0] MODE_IMM = 3'd0;
   localparam logic [2:0] MODE_FIFO = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_word;
   logic csr_write_enable;
   logic csr_write_data;

   four_channel_dma_controller uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // predicted controller state
   logic arm7;
   logic [15:0] ctl_q[4];
   logic [15:0] cnt_q[4];
   logic [27:0] src_q[4];
   logic [27:0] dst_q[4];
   logic [27:0] cur_src[4];
   logic [27:0] cur_dst[4];
   logic [21:0] len_q[4];
   logic [21:0] done_q[4];
   logic reload_q[4];
   logic [3:0] active_q;
   logic [3:0] imm_q;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int mismatches;
   bit quiet;
   int gap_left;
   int stall_left;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [2:0] mode_of(int c);
      return arm7 ? {1'b0, ctl_q[c][13:12]} : ctl_q[c][13:11];
   endfunction

   function automatic logic [21:0] units_of(int c);
      logic [21:0] n;
      if (!arm7) begin
         n = {ctl_q[c][4:0], cnt_q[c]} & 22'h1fffff;
         if (n == 0) n = 22'h200000;
      end else if (c == 3) begin
         n = {6'd0, cnt_q[c]};
         if (n == 0) n = 22'h010000;
      end else begin
         n = {8'd0, cnt_q[c][13:0]};
         if (n == 0) n = 22'h004000;
      end
      return n;
   endfunction

   function automatic logic [27:0] next_addr(logic [27:0] a, logic [1:0] sel, logic wide);
      logic [27:0] unit;
      unit = wide ? 28'd4 : 28'd2;
      if (sel == STEP_DEC) return a - unit;
      if (sel == STEP_FIXED) return a;
      return a + unit;
   endfunction

   function automatic void reload_dest(int c);
      cur_dst[c] = (arm7 && c != 3) ? {1'b0, dst_q[c][26:0]} : dst_q[c];
   endfunction

   function automatic rsp_word_type dma_outcome(req_word_type w);
      rsp_word_type r;
      int c;
      int ch;
      logic was_on;
      logic [2:0] m;
      logic [15:0] ctl;
      r = '0;
      ch = w.channel;
      case (w.op)
         OP_SRC: src_q[ch] = w.write_data[27:0];
         OP_DST: dst_q[ch] = w.write_data[27:0];
         OP_CNT: cnt_q[ch] = w.write_data[15:0];
         OP_CTL: begin
            was_on = ctl_q[ch][15];
            ctl_q[ch] = w.write_data[15:0];
            if (ctl_q[ch][8:7] == 2'd3) r.error_code = ERR_SRC_STEP;
            if (!was_on && ctl_q[ch][15]) begin
               m = mode_of(ch);
               cur_src[ch] = (arm7 && ch == 0) ? {1'b0, src_q[ch][26:0]} : src_q[ch];
               reload_dest(ch);
               len_q[ch] = units_of(ch);
               if (m == MODE_IMM) begin
                  imm_q[ch] = 1'b1;
               end else if (!arm7 && m == MODE_FIFO) begin
                  if (w.fifo_below_half) active_q[ch] = 1'b1;
               end else if ((!arm7 && (m == 3'd4 || m == 3'd6)) || (arm7 && m == 3'd3)) begin
                  r.error_code = ERR_MODE;
               end
               reload_q[ch] = 1'b0;
               done_q[ch] = '0;
            end
         end
         OP_TRIG: begin
            for (c = 0; c < 4; c++) begin
               if (ctl_q[c][15] && mode_of(c) == w.trigger_mode) begin
                  if (reload_q[c]) begin
                     reload_q[c] = 1'b0;
                     len_q[c] = units_of(c);
                     if (ctl_q[c][6:5] == STEP_RELOAD) reload_dest(c);
                  end
                  active_q[c] = 1'b1;
               end
            end
         end
         OP_IMM: begin
            active_q = active_q | imm_q;
            imm_q = '0;
         end
         OP_TICK: begin
            c = 0;
            while (c < 4 && !active_q[c]) c++;
            if (c < 4) begin
               ctl = ctl_q[c];
               if (done_q[c] < len_q[c]) begin
                  r.xfer_valid = 1'b1;
                  r.src_address = cur_src[c];
                  r.dst_address = cur_dst[c];
                  r.xfer_wide = ctl[10];
                  done_q[c] = done_q[c] + 22'd1;
                  cur_src[c] = next_addr(cur_src[c], ctl[8:7] == 2'd3 ? STEP_INC : ctl[8:7],
                                         ctl[10]);
                  cur_dst[c] = next_addr(cur_dst[c], ctl[6:5], ctl[10]);
               end
               if (done_q[c] == len_q[c]) begin
                  if (ctl[14]) begin
                     r.irq_valid = 1'b1;
                     r.irq_channel = c[1:0];
                  end
                  if (ctl[9]) reload_q[c] = 1'b1;
                  else ctl_q[c] = ctl & 16'h7fff;
                  done_q[c] = '0;
                  active_q[c] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      r.active_mask = active_q;
      r.control_readback = ctl_q[ch];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      logic next_valid;
      req_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         next_word = req_word;
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(dma_outcome(req_word));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(1, 17) - 1;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_word <= next_word;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp word %p", rsp_word);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_word !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp mismatch: expected %p actual %p", want, rsp_word);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void put(logic [2:0] op, int ch, logic [31:0] data,
                               logic [2:0] mode = 3'd0, logic below = 1'b0);
      req_word_type w;
      w.op = op;
      w.channel = ch[1:0];
      w.write_data = data;
      w.trigger_mode = mode;
      w.fifo_below_half = below;
      pending_words.push_back(w);
   endfunction

   function automatic void put_ticks(int n);
      for (int i = 0; i < n; i++) put(OP_TICK, 0, $urandom());
   endfunction

   // one complete transfer on a channel with random content
   function automatic void queue_transfer(int ch);
      logic [15:0] ctl;
      logic [2:0] m;
      int n;
      n = $urandom_range(1, 5);
      put(OP_SRC, ch, $urandom());
      put(OP_DST, ch, $urandom());
      put(OP_CNT, ch, {16'($urandom_range(0, 65535)), 16'(n)});
      put(OP_CTL, ch, {16'($urandom_range(0, 65535)), 16'h0000});
      ctl = 16'($urandom_range(0, 65535));
      ctl[15] = 1'b1;
      if (!arm7) ctl[4:0] = '0;
      m = arm7 ? {1'b0, ctl[13:12]} : ctl[13:11];
      put(OP_CTL, ch, {16'($urandom_range(0, 65535)), ctl}, 3'd0,
          1'($urandom_range(0, 1)));
      if (m == MODE_IMM || $urandom_range(0, 7) == 0) put(OP_IMM, ch, $urandom());
      if (m != MODE_IMM) put(OP_TRIG, ch, $urandom(), m, 1'($urandom_range(0, 1)));
      put_ticks(n + $urandom_range(0, 2));
      if (ctl[9] && $urandom_range(0, 1)) begin
         put(OP_TRIG, ch, $urandom(), m);
         put_ticks(n + 1);
      end
   endfunction

   // reload every channel with a single-unit immediate transfer and drain it
   function automatic void queue_flush();
      for (int c = 0; c < 4; c++) begin
         put(OP_CNT, c, 32'd1);
         put(OP_CTL, c, 32'd0);
         put(OP_CTL, c, {16'd0, CTL_ENABLE});
      end
      put(OP_IMM, 0, 32'd0);
      put_ticks(6);
   endfunction

   function automatic void queue_noise();
      logic [31:0] d;
      d = $urandom();
      if ($urandom_range(0, 3) != 0) d[15:0] = d[15:0] & 16'hffe7 & ~16'h001f;
      if ($urandom_range(0, 3) != 0) d[13:3] = d[13:3] & 11'h7fc;
      put(3'($urandom_range(0, 7)), $urandom_range(0, 3), d, 3'($urandom_range(0, 7)),
          1'($urandom_range(0, 1)));
   endfunction

   task automatic drain();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_variant(logic v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      arm7 = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
   endtask

   initial begin
      int budget;
      int queued;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      mismatches = 0;
      quiet = 1'b0;
      arm7 = 1'b0;
      active_q = '0;
      imm_q = '0;
      for (int c = 0; c < 4; c++) begin
         ctl_q[c] = '0; cnt_q[c] = '0; src_q[c] = '0; dst_q[c] = '0;
         cur_src[c] = '0; cur_dst[c] = '0; len_q[c] = '0; done_q[c] = '0;
         reload_q[c] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_variant(1'b0);
      put(OP_TICK, 0, 32'd0);
      put(OP_NONE, 2, 32'hffffffff, 3'd7, 1'b1);
      // wrap of the working addresses
      put(OP_SRC, 0, 32'hfffffffe);
      put(OP_DST, 0, 32'h00000000);
      put(OP_CNT, 0, 32'd2);
      put(OP_CTL, 0, {16'd0, CTL_ENABLE | CTL_IRQ | CTL_WIDE | 16'h0020});
      put(OP_IMM, 0, 32'd0);
      put_ticks(3);
      // invalid source step
      put(OP_SRC, 1, 32'hf0f0f0f0);
      put(OP_CNT, 1, 32'd1);
      put(OP_CTL, 1, {16'd0, CTL_ENABLE | CTL_IRQ | 16'h0180});
      put(OP_IMM, 1, 32'd0);
      put_ticks(2);
      // unimplemented modes, then fifo start
      put(OP_CTL, 2, {16'd0, CTL_ENABLE | 16'h2000});
      put(OP_CTL, 2, 32'd0);
      put(OP_CTL, 2, {16'd0, CTL_ENABLE | 16'h3000});
      put(OP_CTL, 2, 32'd0);
      put(OP_CTL, 2, {16'd0, CTL_ENABLE | 16'h3800}, 3'd0, 1'b1);
      // zero count means the maximum, disabled while still active
      put(OP_CNT, 3, 32'd0);
      put(OP_CTL, 3, {16'd0, CTL_ENABLE | CTL_REPEAT});
      put(OP_IMM, 3, 32'd0);
      put_ticks(2);
      put(OP_CTL, 3, 32'd0);
      put_ticks(2);
      queue_flush();
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_variant(phase[0] ? 1'b0 : 1'b1);
         if (phase == 3) quiet = 1'b1;
         if (phase == 0) begin
            put(OP_CTL, 0, {16'd0, CTL_ENABLE | 16'h3000});
            put(OP_CNT, 1, 32'd0);
            put(OP_CTL, 1, 32'd0);
            put(OP_CTL, 1, {16'd0, CTL_ENABLE});
            put(OP_IMM, 1, 32'd0);
            put_ticks(2);
            queue_flush();
         end
         budget = 460;
         while (budget > 0) begin
            if ($urandom_range(0, 4) == 0) begin
               queue_noise();
               budget--;
            end else begin
               queued = pending_words.size();
               queue_transfer($urandom_range(0, 3));
               if ($urandom_range(0, 6) == 0) queue_flush();
               budget -= pending_words.size() - queued;
            end
            while (pending_words.size() > 40) @(negedge clock);
         end
         queue_flush();
         drain();
      end

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fcdma_pkg.sv
sv/fcdma_pick.sv
sv/four_channel_dma_controller.sv
verif/four_channel_dma_controller_tb.sv
